// File: hdl/sfr_pkg.sv
package sfr_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int LEN_W       = 6;   // holds 0..MAX_PAYLOAD
  localparam int IDX_W       = 5;   // holds 0..MAX_PAYLOAD-1
  localparam int MEM_AW      = IDX_W + 1;   // one bank bit on top
  localparam int MEM_DEPTH   = 2 ** MEM_AW;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_HDR_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RX_ENABLE  = 2'd2;

  localparam logic [7:0] HDR_FIRST_RST  = 8'd170;
  localparam logic [7:0] HDR_SECOND_RST = 8'd85;

  typedef enum logic [2:0] {
    PH_HDR1 = 3'd0,
    PH_HDR2 = 3'd1,
    PH_LEN  = 3'd2,
    PH_SEQ  = 3'd3,
    PH_CMD  = 3'd4,
    PH_PAY  = 3'd5,
    PH_SUM  = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_SHOW
  } back_state_t;

  // one checked frame waiting for emission
  typedef struct packed {
    logic             bank;
    logic [LEN_W-1:0] len;
    logic [7:0]       seq;
    logic [7:0]       cmd;
  } desc_t;

  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

endpackage

// File: hdl/sfr_in_if.sv
interface sfr_in_if;
  import sfr_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       timeout;

  modport source (output valid, output rx_byte, output timeout, input ready);
  modport sink   (input valid, input rx_byte, input timeout, output ready);
endinterface

// File: hdl/sfr_out_if.sv
interface sfr_out_if;
  import sfr_pkg::*;

  logic             valid;
  logic             ready;
  logic [7:0]       command;
  logic [7:0]       sequence_res;
  logic [LEN_W-1:0] payload_len;
  logic [IDX_W-1:0] byte_index;
  logic [7:0]       payload_byte;
  logic             has_byte;
  logic             last;

  modport source (output valid, output command, output sequence_res, output payload_len,
                  output byte_index, output payload_byte, output has_byte, output last,
                  input ready);
  modport sink   (input valid, input command, input sequence_res, input payload_len,
                  input byte_index, input payload_byte, input has_byte, input last,
                  output ready);
endinterface

// File: hdl/sum8_frame_receiver.sv
// A frame's results are shown once its checksum word is accepted and the frame
//   is queued (a zero-length frame skips the payload memory read).
// Throughput: one input word per cycle while the input is not stalled; each result
//   waits for the registered read of the payload memory ahead of the output register.
// Input stalls only while two checked frames wait for emission (both banks full).
// Reset (synchronous, rst_n low): parser hunts the first header, queue empty,
//   headers 170/85, reception enabled.
module sum8_frame_receiver
  import sfr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  sfr_in_if.sink               in_ch,
  sfr_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata
);

  logic    push, pop, q_empty, q_full;
  desc_t   push_desc, head;
  mem_wr_t mem_wr;

  sfr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .push      (push),
    .desc      (push_desc),
    .mem_wr    (mem_wr)
  );

  sfr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  sfr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .head    (head),
    .mem_wr  (mem_wr),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

// File: hdl/sfr_front.sv
module sfr_front
  import sfr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  sfr_in_if.sink               in_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata,
  input  logic                 q_full,
  output logic                 push,
  output desc_t                desc,
  output mem_wr_t              mem_wr
);

  logic [7:0]       hdr_first_r, hdr_second_r;
  logic             rx_en_r;
  phase_t           phase_r, phase_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [7:0]       seq_r, seq_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic             bank_r, bank_nxt;
  logic             accept;
  logic [7:0]       b;
  logic [LEN_W-1:0] cnt_inc;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;
  assign cnt_inc     = cnt_r + LEN_W'(1);
  assign desc        = '{bank: bank_r, len: len_r, seq: seq_r, cmd: cmd_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_first_r  <= HDR_FIRST_RST;
      hdr_second_r <= HDR_SECOND_RST;
      rx_en_r      <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HDR_FIRST:  hdr_first_r  <= cfg_wdata;
        CFG_HDR_SECOND: hdr_second_r <= cfg_wdata;
        CFG_RX_ENABLE:  rx_en_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    sum_nxt     = sum_r;
    cnt_nxt     = cnt_r;
    len_nxt     = len_r;
    seq_nxt     = seq_r;
    cmd_nxt     = cmd_r;
    bank_nxt    = bank_r;
    push        = 1'b0;
    mem_wr.we   = 1'b0;
    mem_wr.addr = {bank_r, cnt_r[IDX_W-1:0]};
    mem_wr.data = b;
    if (accept) begin
      if (in_ch.timeout || !rx_en_r) begin
        phase_nxt = PH_HDR1;
      end else begin
        unique case (phase_r)
          PH_HDR1: begin
            sum_nxt   = b;
            phase_nxt = (b == hdr_first_r) ? PH_HDR2 : PH_HDR1;
          end
          PH_HDR2: begin
            sum_nxt   = sum_r + b;
            phase_nxt = (b == hdr_second_r) ? PH_LEN : PH_HDR1;
          end
          PH_LEN: begin
            if (b > 8'(MAX_PAYLOAD)) begin
              phase_nxt = PH_HDR1;
            end else begin
              len_nxt   = b[LEN_W-1:0];
              sum_nxt   = sum_r + b;
              phase_nxt = PH_SEQ;
            end
          end
          PH_SEQ: begin
            seq_nxt   = b;
            sum_nxt   = sum_r + b;
            phase_nxt = PH_CMD;
          end
          PH_CMD: begin
            cmd_nxt   = b;
            sum_nxt   = sum_r + b;
            cnt_nxt   = '0;
            phase_nxt = (len_r == '0) ? PH_SUM : PH_PAY;
          end
          PH_PAY: begin
            mem_wr.we = 1'b1;
            sum_nxt   = sum_r + b;
            if (cnt_inc >= len_r) begin
              cnt_nxt   = '0;
              phase_nxt = PH_SUM;
            end else begin
              cnt_nxt = cnt_inc;
            end
          end
          PH_SUM: begin
            if (sum_r == b) begin
              push     = 1'b1;
              bank_nxt = !bank_r;
            end
            sum_nxt   = '0;
            phase_nxt = PH_HDR1;
          end
          default: phase_nxt = PH_HDR1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR1;
      sum_r   <= '0;
      cnt_r   <= '0;
      len_r   <= '0;
      seq_r   <= '0;
      cmd_r   <= '0;
      bank_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      seq_r   <= seq_nxt;
      cmd_r   <= cmd_nxt;
      bank_r  <= bank_nxt;
    end
  end

endmodule

// File: hdl/sfr_queue.sv
module sfr_queue
  import sfr_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  input  logic  pop,
  output desc_t head,
  output logic  empty,
  output logic  full
);

  // two entries, one per payload bank
  desc_t      entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign head  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: hdl/sfr_back.sv
module sfr_back
  import sfr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_empty,
  input  desc_t   head,
  input  mem_wr_t mem_wr,
  output logic    pop,
  sfr_out_if.source out_ch
);

  logic [7:0]        mem [MEM_DEPTH];
  logic [7:0]        rd_data_r;
  logic [MEM_AW-1:0] rd_addr;

  back_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] idx_inc;
  logic             load_word, load_empty;

  logic [7:0]       cmd_r, seq_r, byte_r;
  logic [LEN_W-1:0] len_r;
  logic [IDX_W-1:0] oidx_r;
  logic             has_r, last_r;

  assign idx_inc = idx_r + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (mem_wr.we) mem[mem_wr.addr] <= mem_wr.data;
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    rd_addr    = {head.bank, idx_r};
    load_word  = 1'b0;
    load_empty = 1'b0;
    pop        = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          idx_nxt = '0;
          if (head.len == '0) begin
            load_empty = 1'b1;
            state_nxt  = BK_SHOW;
          end else begin
            rd_addr   = {head.bank, {IDX_W{1'b0}}};
            state_nxt = BK_FETCH;
          end
        end
      end
      BK_FETCH: begin
        load_word = 1'b1;
        state_nxt = BK_SHOW;
      end
      BK_SHOW: begin
        if (out_ch.ready) begin
          if (last_r) begin
            pop       = 1'b1;
            state_nxt = BK_IDLE;
          end else begin
            idx_nxt   = idx_inc;
            rd_addr   = {head.bank, idx_inc};
            state_nxt = BK_FETCH;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_word || load_empty) begin
      cmd_r  <= head.cmd;
      seq_r  <= head.seq;
      len_r  <= head.len;
      oidx_r <= load_word ? idx_r : '0;
      byte_r <= load_word ? rd_data_r : 8'd0;
      has_r  <= load_word;
      last_r <= load_empty || ((LEN_W'(idx_r) + LEN_W'(1)) == head.len);
    end
  end

  assign out_ch.valid        = (state_r == BK_SHOW);
  assign out_ch.command      = cmd_r;
  assign out_ch.sequence_res = seq_r;
  assign out_ch.payload_len  = len_r;
  assign out_ch.byte_index   = oidx_r;
  assign out_ch.payload_byte = byte_r;
  assign out_ch.has_byte     = has_r;
  assign out_ch.last         = last_r;

  // a shown word always belongs to the frame at the queue head
  a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !q_empty)
    else $error("result shown with no frame queued");

  // an empty-frame word is the only word of its frame
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.has_byte) |-> (out_ch.last && out_ch.payload_len == '0))
    else $error("empty-frame word malformed");

  // after a non-final word is taken the next byte is fetched
  a_next_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last) |=> (state_r == BK_FETCH))
    else $error("frame emission stopped early");

endmodule

// File: tb/sum8_frame_receiver_test.sv
`timescale 1ns / 1ps

module sum8_frame_receiver_test;
  import sfr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0]       cmd;
    logic [7:0]       seq;
    logic [LEN_W-1:0] len;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
    logic             has_byte;
    logic             last_word;
  } frame_word_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0] cfg_wdata;

  sfr_in_if  in_ch ();
  sfr_out_if out_ch ();

  sum8_frame_receiver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // parser copy: configuration and frame state
  logic [7:0]       cfg_hdr_first  = HDR_FIRST_RST;
  logic [7:0]       cfg_hdr_second = HDR_SECOND_RST;
  logic             cfg_rx_on      = 1'b1;
  phase_t           prs_phase      = PH_HDR1;
  logic [7:0]       prs_sum        = '0;
  logic [LEN_W-1:0] prs_count      = '0;
  logic [LEN_W-1:0] prs_len        = '0;
  logic [7:0]       prs_seq        = '0;
  logic [7:0]       prs_cmd        = '0;
  logic [7:0]       prs_store [MAX_PAYLOAD];

  frame_word_t words_due [$];
  int          mismatch_count   = 0;
  int          frame_bytes_sent = 0;
  bit          sender_idles     = 1'b1;
  bit          sink_idles       = 1'b1;
  int          hold_req         = 0;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  initial begin
    #400_000;
    $display("tb: failure");
    $finish;
  end

  // step the parser copy by one accepted word, queue the words of a good frame
  task automatic parse_rx_word(input logic [7:0] b, input logic tmo);
    frame_word_t w;
    int i;
    if (tmo || !cfg_rx_on) begin
      prs_phase = PH_HDR1;
      return;
    end
    case (prs_phase)
      PH_HDR1: begin
        prs_sum = b;
        if (b == cfg_hdr_first) prs_phase = PH_HDR2;
      end
      PH_HDR2: begin
        prs_sum = prs_sum + b;
        // a mismatch is not retried as a first header
        if (b == cfg_hdr_second) prs_phase = PH_LEN;
        else prs_phase = PH_HDR1;
      end
      PH_LEN: begin
        if (b > MAX_PAYLOAD) begin
          prs_phase = PH_HDR1;
        end else begin
          prs_len = b[LEN_W-1:0];
          prs_sum = prs_sum + b;
          prs_phase = PH_SEQ;
        end
      end
      PH_SEQ: begin
        prs_seq = b;
        prs_sum = prs_sum + b;
        prs_phase = PH_CMD;
      end
      PH_CMD: begin
        prs_cmd = b;
        prs_sum = prs_sum + b;
        prs_count = '0;
        if (prs_len == 0) prs_phase = PH_SUM;
        else prs_phase = PH_PAY;
      end
      PH_PAY: begin
        prs_store[prs_count[IDX_W-1:0]] = b;
        prs_sum = prs_sum + b;
        prs_count = prs_count + 1'b1;
        if (prs_count >= prs_len) begin
          prs_count = '0;
          prs_phase = PH_SUM;
        end
      end
      PH_SUM: begin
        if (prs_sum == b) begin
          if (prs_len == 0) begin
            w = '{prs_cmd, prs_seq, prs_len, '0, 8'h00, 1'b0, 1'b1};
            words_due.push_back(w);
          end else begin
            for (i = 0; i < int'(prs_len); i++) begin
              w = '{prs_cmd, prs_seq, prs_len, i[IDX_W-1:0], prs_store[i], 1'b1,
                    (i + 1 == int'(prs_len))};
              words_due.push_back(w);
            end
          end
        end
        prs_sum = '0;
        prs_phase = PH_HDR1;
      end
      default: prs_phase = PH_HDR1;
    endcase
  endtask

  task automatic send_word(input logic [7:0] b, input logic tmo);
    int gap;
    gap = sender_idles ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    in_ch.timeout <= tmo;
    do @(posedge clk); while (!in_ch.ready);
    parse_rx_word(b, tmo);
  endtask

  // header, length, seq, cmd, payload, checksum; keep cuts the frame short
  task automatic send_frame(input int len, input logic [7:0] seq, input logic [7:0] cmd,
                            input bit bad_sum, input int keep = -1, input int fill = -1);
    logic [7:0] body [$];
    logic [7:0] sum;
    int i;
    body = {cfg_hdr_first, cfg_hdr_second, 8'(len), seq, cmd};
    for (i = 0; i < len; i++) body.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    sum = '0;
    for (i = 0; i < body.size(); i++) sum = sum + body[i];
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    body.push_back(sum);
    if (keep < 0 || keep > body.size()) keep = body.size();
    for (i = 0; i < keep; i++) send_word(body[i], 1'b0);
    frame_bytes_sent += keep;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_HDR_FIRST:  cfg_hdr_first = val;
      CFG_HDR_SECOND: cfg_hdr_second = val;
      CFG_RX_ENABLE:  cfg_rx_on = val[0];
      default: ;
    endcase
  endtask

  function automatic int rand_len();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return MAX_PAYLOAD;
    if (r < 3) return $urandom_range(9, MAX_PAYLOAD - 1);
    return $urandom_range(0, 8);
  endfunction

  task automatic report_word(input string what, input frame_word_t want,
                             input frame_word_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s: want cmd=%h seq=%h len=%0d idx=%0d byte=%h has=%b last=%b",
               what, want.cmd, want.seq, want.len, want.idx, want.data, want.has_byte,
               want.last_word);
      $display("  got cmd=%h seq=%h len=%0d idx=%0d byte=%h has=%b last=%b",
               got.cmd, got.seq, got.len, got.idx, got.data, got.has_byte,
               got.last_word);
    end
  endtask

  always @(posedge clk) begin : result_check
    frame_word_t got;
    frame_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.command, out_ch.sequence_res, out_ch.payload_len, out_ch.byte_index,
              out_ch.payload_byte, out_ch.has_byte, out_ch.last};
      if (words_due.size() == 0) begin
        report_word("unexpected word", '0, got);
      end else begin
        want = words_due.pop_front();
        if (got !== want) report_word("word mismatch", want, got);
      end
    end
  end

  // result side pacing; hold_req asks for one long hold-off
  initial begin : sink_pacing
    int n;
    forever begin
      if (hold_req > 0) begin
        out_ch.ready <= 1'b0;
        n = hold_req;
        hold_req = 0;
        repeat (n) @(posedge clk);
      end else begin
        n = sink_idles ? $urandom_range(0, 5) : 0;
        if (n > 0) begin
          out_ch.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready) && hold_req == 0);
    end
  end

  task automatic test_frame_shapes();
    send_frame(0, 8'h00, 8'h00, 1'b0);
    send_frame(1, 8'hFF, 8'hFF, 1'b0, -1, 8'hFF);
    send_frame(2, 8'h5A, 8'hA5, 1'b0, -1, 8'h00);
    send_frame(MAX_PAYLOAD, 8'($urandom), 8'($urandom), 1'b0);
  endtask

  task automatic test_special_cases();
    // timeout in the middle of a frame, with a header-like byte
    send_frame(4, 8'h11, 8'h22, 1'b0, 6);
    send_word(cfg_hdr_first, 1'b1);
    send_frame(0, 8'h33, 8'h44, 1'b0);
    // second header wrong: a repeated first header does not restart the hunt
    send_word(cfg_hdr_first, 1'b0);
    send_word(cfg_hdr_first, 1'b0);
    send_frame(3, 8'h01, 8'h02, 1'b0);
    // lengths past the buffer drop the frame
    send_frame(MAX_PAYLOAD + 1, 8'h00, 8'h00, 1'b0, 3);
    send_frame(255, 8'h00, 8'h00, 1'b0, 3);
    send_frame(1, 8'h80, 8'h7F, 1'b0);
    // bad checksum, then a good frame
    send_frame(5, 8'h10, 8'h20, 1'b1);
    send_frame(0, 8'h10, 8'h20, 1'b1);
    send_frame(2, 8'h30, 8'h40, 1'b0);
  endtask

  task automatic test_rx_disable();
    write_reg(CFG_RX_ENABLE, 8'h00);
    send_frame(2, 8'h55, 8'hAA, 1'b0);
    write_reg(CFG_RX_ENABLE, 8'h01);
    send_frame(3, 8'h66, 8'h99, 1'b0, 5);
    write_reg(CFG_RX_ENABLE, 8'h02);
    send_word(8'($urandom), 1'b0);
    write_reg(CFG_RX_ENABLE, 8'hFF);
    write_reg(CFG_UNUSED, 8'hFF);
    send_frame(3, 8'h67, 8'h98, 1'b0);
  endtask

  task automatic test_backpressure();
    settle();
    sender_idles = 1'b0;
    hold_req = 400;
    repeat (4) send_frame(8, 8'($urandom), 8'($urandom), 1'b0);
    settle();
    sender_idles = 1'b1;
  endtask

  task automatic test_random_traffic(input int goal);
    int start;
    int pick;
    int len;
    start = frame_bytes_sent;
    while (frame_bytes_sent - start < goal) begin
      sender_idles = ($urandom_range(0, 3) != 0);
      sink_idles   = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 19);
      if (pick < 13) begin
        send_frame(rand_len(), 8'($urandom), 8'($urandom), 1'b0);
      end else if (pick < 15) begin
        send_frame(rand_len(), 8'($urandom), 8'($urandom), 1'b1);
      end else if (pick < 17) begin
        repeat ($urandom_range(1, 4)) send_word(8'($urandom), $urandom_range(0, 7) == 0);
      end else if (pick < 19) begin
        len = rand_len();
        send_frame(len, 8'($urandom), 8'($urandom), 1'b0, $urandom_range(1, len + 5));
        if ($urandom_range(0, 1)) send_word(8'($urandom), 1'b1);
      end else begin
        send_frame($urandom_range(MAX_PAYLOAD + 1, 255), 8'($urandom), 8'($urandom), 1'b0, 3);
      end
    end
  endtask

  initial begin : main
    int waited;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    in_ch.timeout <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_wdata     <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_frame_shapes();
    test_special_cases();
    test_rx_disable();
    test_backpressure();

    test_random_traffic(50);
    write_reg(CFG_HDR_FIRST, 8'h00);
    write_reg(CFG_HDR_SECOND, 8'hFF);
    test_random_traffic(35);
    write_reg(CFG_HDR_FIRST, 8'hFF);
    write_reg(CFG_HDR_SECOND, 8'h00);
    test_random_traffic(35);
    // equal header bytes
    write_reg(CFG_HDR_FIRST, 8'($urandom));
    write_reg(CFG_HDR_SECOND, cfg_hdr_first);
    test_random_traffic(25);
    write_reg(CFG_HDR_FIRST, 8'($urandom));
    write_reg(CFG_HDR_SECOND, 8'($urandom));
    test_random_traffic(25);

    in_ch.valid <= 1'b0;
    waited = 0;
    while (words_due.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (words_due.size() != 0) begin
      mismatch_count++;
      $display("%0d expected words never arrived", words_due.size());
    end
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/sfr_pkg.sv
hdl/sfr_in_if.sv
hdl/sfr_out_if.sv
hdl/sfr_front.sv
hdl/sfr_queue.sv
hdl/sfr_back.sv
hdl/sum8_frame_receiver.sv
tb/sum8_frame_receiver_test.sv
